### hdl/wsm_pkg.sv
// Shared types and constants for the wildcard substring matcher.
package wsm_pkg;

  localparam int CHAR_BITS      = 8;
  localparam int CFG_INDEX_BITS = 1;
  localparam int CFG_DATA_BITS  = 8;

  // Configuration register indexes
  localparam logic [CFG_INDEX_BITS-1:0] CFG_WC_ENABLE = 1'b0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_WC_CODE   = 1'b1;

  // Reset values of the configuration registers
  localparam logic                 WC_ENABLE_RST = 1'b1;
  localparam logic [CHAR_BITS-1:0] WC_CODE_RST   = 8'd63;

  typedef enum logic {
    ACT_PATTERN = 1'b0,
    ACT_TEXT    = 1'b1
  } action_t;

  // Broadcast from the top level to every compare cell
  typedef struct packed {
    logic                 load;       // pattern beat
    logic                 text;       // text beat
    logic                 clear;      // drop all partial matches
    logic                 wc_en;
    logic [CHAR_BITS-1:0] wc_code;
    logic [CHAR_BITS-1:0] char_code;
  } cell_ctrl_t;

endpackage

### hdl/wsm_cell.sv
// One compare cell: a pattern byte and its prefix-match bit.
module wsm_cell
  import wsm_pkg::*;
#(
  parameter int INDEX = 0,
  parameter int LEN_W = 6
) (
  input  logic             clk,
  input  logic             rst,
  input  cell_ctrl_t       ctrl,
  input  logic [LEN_W-1:0] load_index,
  input  logic [LEN_W-1:0] pattern_length,
  input  logic             prev_match,
  output logic             match,
  output logic             hit
);

  logic [CHAR_BITS-1:0] pat;
  logic                 fits;
  logic                 active;
  logic                 tail;
  logic                 match_next;

  assign fits   = (ctrl.wc_en && (pat == ctrl.wc_code)) || (pat == ctrl.char_code);
  assign active = LEN_W'(INDEX) < pattern_length;
  assign tail   = pattern_length == LEN_W'(INDEX + 1);

  // prefix 0..INDEX matches ending at this byte
  assign match_next = prev_match && fits;
  assign hit        = ctrl.text && tail && match_next;

  always_ff @(posedge clk) begin
    if (ctrl.load && (load_index == LEN_W'(INDEX))) begin
      pat <= ctrl.char_code;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      match <= 1'b0;
    end else if (ctrl.text && active) begin
      match <= match_next;
    end
  end

endmodule

### hdl/wildcard_substring_match.sv
// Top level: wildcard substring matcher built on a chain of compare cells.
//
//   channel  | handshake              | payload
//   ---------+------------------------+----------------------------------
//   in       | in_valid / in_ready    | action, char_code, last
//   out      | out_valid / out_ready  | position, matched, end_of_text
//   cfg      | cfg_wr_en (no wait)    | cfg_index, cfg_data
//
// One beat per cycle on the input while in_ready is high; every compare cell
// within the loaded pattern length updates its match bit from its left neighbor in the cycle the text byte is taken.
// A result shows in the output register the cycle after its beat.
// The input stalls only while a result waits and out_ready is low.
// Reset clears lengths, counters, match bits and the output valid flag; the pattern
// bytes themselves are not reset.
module wildcard_substring_match
  import wsm_pkg::*;
#(
  parameter int MAX_PATTERN   = 32,
  parameter int POSITION_BITS = 20
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      action,
  input  logic [CHAR_BITS-1:0]      char_code,
  input  logic                      last,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [POSITION_BITS-1:0]  position,
  output logic                      matched,
  output logic                      end_of_text,
  input  logic                      cfg_wr_en,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

  localparam int LEN_W   = $clog2(MAX_PATTERN + 1);
  localparam int COUNT_W = POSITION_BITS + 1;
  localparam int START_W = POSITION_BITS + 2;
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
  localparam logic [START_W-1:0] POS_MAX   = START_W'({POSITION_BITS{1'b1}});

  logic                 wc_enable;
  logic [CHAR_BITS-1:0] wc_code;
  logic [LEN_W-1:0]     pattern_length;
  logic [LEN_W-1:0]     load_index;
  logic [LEN_W-1:0]     load_index_inc;
  logic [COUNT_W-1:0]   text_count;
  logic [START_W-1:0]   start;
  logic [START_W-1:0]   start_sat;

  logic                   accept;
  logic                   load_beat;
  logic                   text_beat;
  logic                   restart;
  logic                   hit;
  cell_ctrl_t             ctrl;
  logic [MAX_PATTERN:0]   chain;
  logic [MAX_PATTERN-1:0] hit_vec;

  assign in_ready  = !out_valid || out_ready;
  assign accept    = in_valid && in_ready;
  assign load_beat = accept && (action == ACT_PATTERN);
  assign text_beat = accept && (action == ACT_TEXT);
  assign restart   = load_beat && (load_index == '0);

  assign ctrl.load      = load_beat;
  assign ctrl.text      = text_beat;
  assign ctrl.clear     = restart || (text_beat && last);
  assign ctrl.wc_en     = wc_enable;
  assign ctrl.wc_code   = wc_code;
  assign ctrl.char_code = char_code;

  // Empty prefix always matches
  assign chain[0] = 1'b1;

  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
    wsm_cell #(
      .INDEX (k),
      .LEN_W (LEN_W)
    ) u_cell (
      .clk            (clk),
      .rst            (rst),
      .ctrl           (ctrl),
      .load_index     (load_index),
      .pattern_length (pattern_length),
      .prev_match     (chain[k]),
      .match          (chain[k+1]),
      .hit            (hit_vec[k])
    );
  end

  // Only the tail cell of the loaded pattern can raise its hit line
  assign hit = |hit_vec;

  assign load_index_inc = (load_index < LEN_W'(MAX_PATTERN)) ? load_index + 1'b1 : load_index;

  assign start     = START_W'(text_count) + 1'b1 - START_W'(pattern_length);
  assign start_sat = (start > POS_MAX) ? POS_MAX : start;

  always_ff @(posedge clk) begin
    if (rst) begin
      wc_enable <= WC_ENABLE_RST;
      wc_code   <= WC_CODE_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_WC_ENABLE: wc_enable <= cfg_data[0];
        CFG_WC_CODE:   wc_code   <= cfg_data[CHAR_BITS-1:0];
        default:       ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length <= '0;
      load_index     <= '0;
    end else if (load_beat) begin
      if (last) begin
        pattern_length <= load_index_inc;
        load_index     <= '0;
      end else begin
        if (restart) begin
          pattern_length <= '0;
        end
        load_index <= load_index_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      text_count <= '0;
    end else if (text_beat) begin
      if (last) begin
        text_count <= '0;
      end else if (text_count < COUNT_MAX) begin
        text_count <= text_count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (text_beat && (hit || last)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (text_beat && (hit || last)) begin
      position    <= hit ? start_sat[POSITION_BITS-1:0] : '0;
      matched     <= hit;
      end_of_text <= last;
    end
  end

endmodule

### hdl/wsm_checker.sv
// Port-level checks for the wildcard substring matcher, bound to the top level.
module wsm_checker
  import wsm_pkg::*;
#(
  parameter int POSITION_BITS = 20
) (
  input logic                     clk,
  input logic                     rst,
  input logic                     in_valid,
  input logic                     in_ready,
  input logic                     action,
  input logic                     last,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic [POSITION_BITS-1:0] position,
  input logic                     matched,
  input logic                     end_of_text
);

  // A result without a match is only ever the end marker
  a_bare_is_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && !matched |-> end_of_text)
    else $error("result with no match and no end marker");

  a_bare_pos_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !matched |-> position == '0)
    else $error("end marker carries a nonzero position");

  // The last text beat always produces a result beat next cycle
  a_end_follows: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (action == ACT_TEXT) && last |=> out_valid && end_of_text)
    else $error("last text beat gave no end marker");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(position) && $stable(matched))
    else $error("stalled result changed");

endmodule

bind wildcard_substring_match wsm_checker #(
  .POSITION_BITS (POSITION_BITS)
) u_wsm_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .action      (action),
  .last        (last),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .position    (position),
  .matched     (matched),
  .end_of_text (end_of_text)
);
